// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the bound assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`define CHK_LAT2(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ppdf_pkg.sv =====
package ppdf_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [13:0] byte_address;
        logic [7:0]  byte_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0] duty;
        logic       playing;
    } t_out_item;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_FORMAT   = 3'd0;
    localparam logic [2:0] REG_CHANNELS = 3'd1;
    localparam logic [2:0] REG_STEP     = 3'd2;
    localparam logic [2:0] REG_VOLUME   = 3'd3;
    localparam logic [2:0] REG_LENGTH   = 3'd4;

    localparam int PADDR_W = 5;
    localparam int ADDR_XW = 21;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;

    localparam logic [7:0]  MID_LEVEL = 8'd128;
    localparam logic [7:0]  SIGN_FLIP = 8'h80;
    localparam int          FRAC_BITS = 12;
    localparam logic [9:0]  VOL_FULL  = 10'd1000;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;

    // duty = floor(level * 4 * vol / 1000) = (level * vol * COEF_UNIT) >> DIV_SHIFT,
    // with COEF_UNIT = 4 * ceil(2^30 / 1000); exact for all products below 2^20.
    localparam logic [22:0] COEF_UNIT     = 23'd4294968;
    localparam logic [32:0] VOL_COEF_FULL = 33'd4294968000;
    localparam int          DIV_SHIFT     = 30;

    localparam logic [1:0]  RST_FORMAT   = 2'd0;
    localparam logic [3:0]  RST_CHANNELS = 4'd1;
    localparam logic [15:0] RST_STEP     = 16'd4096;
    localparam logic [9:0]  RST_VOLUME   = 10'd1000;
    localparam logic [14:0] RST_LENGTH   = 15'd0;

    typedef struct packed {
        logic [1:0]  sample_format;
        logic [3:0]  channel_count;
        logic [15:0] step_size;
        logic [14:0] data_length;
        logic [32:0] vol_coef;
    } t_cfg;

endpackage

// ===== rtl/ppdf_ram.sv =====
module ppdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ppdf_cfg.sv =====
module ppdf_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [ppdf_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output ppdf_pkg::t_cfg               o_cfg
);
    import ppdf_pkg::*;

    logic [1:0]  r_sample_format;
    logic [3:0]  r_channel_count;
    logic [15:0] r_step_size;
    logic [9:0]  r_volume;
    logic [14:0] r_data_length;
    logic [32:0] r_vol_coef;
    logic [32:0] n_vol_coef;
    logic [9:0]  vol_eff;
    logic [2:0]  reg_idx;
    logic        wr;

    assign reg_idx = i_paddr[PADDR_W-1:2];
    assign wr      = i_psel & i_penable & i_pwrite;

    // Clamp volume, then fold it into the reciprocal scale factor.
    assign vol_eff    = (r_volume > VOL_FULL) ? VOL_FULL : r_volume;
    assign n_vol_coef = 33'(33'(vol_eff) * 33'(COEF_UNIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= RST_FORMAT;
            r_channel_count <= RST_CHANNELS;
            r_step_size     <= RST_STEP;
            r_volume        <= RST_VOLUME;
            r_data_length   <= RST_LENGTH;
            r_vol_coef      <= VOL_COEF_FULL;
        end else begin
            r_vol_coef <= n_vol_coef;
            if (wr) begin
                unique case (reg_idx)
                    REG_FORMAT:   r_sample_format <= i_pwdata[1:0];
                    REG_CHANNELS: r_channel_count <= i_pwdata[3:0];
                    REG_STEP:     r_step_size     <= i_pwdata[15:0];
                    REG_VOLUME:   r_volume        <= i_pwdata[9:0];
                    REG_LENGTH:   r_data_length   <= i_pwdata[14:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_FORMAT:   o_prdata = {30'd0, r_sample_format};
            REG_CHANNELS: o_prdata = {28'd0, r_channel_count};
            REG_STEP:     o_prdata = {16'd0, r_step_size};
            REG_VOLUME:   o_prdata = {22'd0, r_volume};
            REG_LENGTH:   o_prdata = {17'd0, r_data_length};
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg.sample_format = r_sample_format;
    assign o_cfg.channel_count = r_channel_count;
    assign o_cfg.step_size     = r_step_size;
    assign o_cfg.data_length   = r_data_length;
    assign o_cfg.vol_coef      = r_vol_coef;

endmodule

// ===== rtl/pcm_pwm_dac_feeder_core.sv =====
// PCM-to-PWM duty feeder. Load requests (op 0) write one byte of the sample store and
// complete in the accept cycle with no result. Start, stop and tick requests each give
// one result {duty, playing}. For a tick, the accept cycle issues the store read at
// the current position (position + 1 for signed 16-bit, where the high byte carries
// the level), and the execute stage then turns the byte into a level, scales it by
// volume through one multiply with a precomputed reciprocal factor, and advances the
// phase and position. The store memory read is registered. A start, stop or tick
// holds the execute stage until it retires, and only then is the next request taken;
// loads may follow one another every cycle while the execute stage is empty. A
// finished result waits in the output register while the next request is taken;
// intake stalls whenever a start, stop or tick sits in the execute stage, and stays
// stalled while that request waits behind an unaccepted result. The sample store
// needs no clearing if entries never written are not read; the user must ensure
// this, the block does not enforce it. Register writes through the APB port apply
// from the next edge; the scale factor follows volume through one more register.
module pcm_pwm_dac_feeder_core #(
    parameter int STORE_DEPTH = 16384
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ppdf_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ppdf_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppdf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ppdf_pkg::*;

    localparam int                 AW      = $clog2(STORE_DEPTH);
    localparam logic [ADDR_XW-1:0] DEPTH_X = ADDR_XW'(STORE_DEPTH);

    t_cfg cfg;

    // Execute stage and playback state
    logic        r_exec_v;
    t_op         r_exec_op;
    logic        r_rd_zero;
    logic [15:0] r_pos;
    logic [11:0] r_phase;
    logic        r_active;
    logic        r_out_v;
    t_out_item   r_out_item;

    logic [15:0] n_pos;
    logic [11:0] n_phase;
    logic        n_active;
    t_out_item   n_result;

    logic               accept;
    logic               exec_done;
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_XW-1:0] wr_addr_x;
    logic [ADDR_XW-1:0] rd_addr_x;
    logic [7:0]         rd_data;

    logic               at_end;
    logic               s16_whole;
    logic [7:0]         byte_eff;
    logic [7:0]         level;
    logic [16:0]        phase_sum;
    logic [4:0]         steps;
    logic [7:0]         steps_cc;
    logic [8:0]         adv;
    logic [16:0]        pos_sum;
    logic [15:0]        pos_adv;
    logic [40:0]        prod;

    ppdf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    assign pready = 1'b1;

    // Intake: one request in the execute stage at a time; loads retire at once.
    assign o_in_stall = r_exec_v;
    assign accept     = i_in_valid & ~r_exec_v;
    assign exec_done  = r_exec_v & (~r_out_v | ~i_out_stall);

    // Store ports: drop loads beyond the store, read zero beyond the store.
    assign wr_addr_x = {{(ADDR_XW-14){1'b0}}, i_in_item.byte_address};
    assign wr_en     = accept & (i_in_item.op == OP_LOAD) & (wr_addr_x < DEPTH_X);
    assign rd_addr_x = (cfg.sample_format == FMT_S16) ?
                       {{(ADDR_XW-16){1'b0}}, r_pos} + ADDR_XW'(1) :
                       {{(ADDR_XW-16){1'b0}}, r_pos};
    assign rd_en     = accept & (i_in_item.op == OP_TICK);

    ppdf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr_x[AW-1:0]),
        .i_wr_data (i_in_item.byte_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_x[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Level from the fetched byte
    assign at_end    = r_pos >= {1'b0, cfg.data_length};
    assign s16_whole = ({1'b0, r_pos} + 17'd1) < {2'b0, cfg.data_length};
    assign byte_eff  = r_rd_zero ? 8'd0 : rd_data;

    always_comb begin
        case (cfg.sample_format)
            FMT_U8:  level = byte_eff;
            FMT_S16: level = s16_whole ? (byte_eff ^ SIGN_FLIP) : MID_LEVEL;
            default: level = MID_LEVEL;
        endcase
    end

    // Phase accumulator and position advance
    assign phase_sum = {5'd0, r_phase} + {1'b0, cfg.step_size};
    assign steps     = phase_sum[16:FRAC_BITS];
    assign steps_cc  = {3'd0, steps} * {4'd0, cfg.channel_count};

    always_comb begin
        case (cfg.sample_format)
            FMT_U8:  adv = {1'b0, steps_cc};
            FMT_S16: adv = {steps_cc, 1'b0};
            default: adv = {4'd0, steps};
        endcase
    end

    assign pos_sum = {1'b0, r_pos} + {8'd0, adv};
    assign pos_adv = pos_sum[16] ? POS_MAX : pos_sum[15:0];

    // Volume scaling: level times the reciprocal-folded factor, keep the integer part.
    assign prod = {33'd0, level} * {8'd0, cfg.vol_coef};

    always_comb begin
        n_pos            = r_pos;
        n_phase          = r_phase;
        n_active         = r_active;
        n_result.duty    = 10'd0;
        n_result.playing = 1'b0;
        unique case (r_exec_op)
            OP_START: begin
                n_pos            = 16'd0;
                n_phase          = 12'd0;
                n_active         = 1'b1;
                n_result.playing = 1'b1;
            end
            OP_STOP: begin
                n_active = 1'b0;
            end
            OP_TICK: begin
                if (!r_active || at_end) begin
                    // Idle or past the data: silent, hold position, end playback at the end.
                    n_active         = r_active & ~at_end;
                    n_result.playing = r_active & ~at_end;
                end else begin
                    n_phase          = phase_sum[FRAC_BITS-1:0];
                    n_pos            = pos_adv;
                    n_result.duty    = prod[DIV_SHIFT +: 10];
                    n_result.playing = 1'b1;
                end
            end
            OP_LOAD: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec_v  <= 1'b0;
            r_exec_op <= OP_LOAD;
            r_pos     <= 16'd0;
            r_phase   <= 12'd0;
            r_active  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            // Advance a non-load request into the execute stage
            if (accept && (i_in_item.op != OP_LOAD)) begin
                r_exec_v  <= 1'b1;
                r_exec_op <= i_in_item.op;
                r_rd_zero <= rd_addr_x >= DEPTH_X;
            end else if (exec_done) begin
                r_exec_v <= 1'b0;
            end
            // Retire: commit state and hand the result to the output register
            if (exec_done) begin
                r_pos      <= n_pos;
                r_phase    <= n_phase;
                r_active   <= n_active;
                r_out_v    <= 1'b1;
                r_out_item <= n_result;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/ppdf_checker.sv =====
`include "assert_macros.svh"

module ppdf_sva (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input ppdf_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ppdf_pkg::t_out_item o_out_item
);
    import ppdf_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid & ~o_in_stall;

    // Hold a stalled result
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item))

    // Silence whenever playback is not running
    `CHK_SAME(a_silent_idle, i_clk, i_rst_n, o_out_valid && !o_out_item.playing,
        o_out_item.duty == 10'd0)

    // A load produces no result
    `CHK_NEXT(a_load_quiet, i_clk, i_rst_n,
        in_acc && (i_in_item.op == OP_LOAD) && !o_out_valid, !o_out_valid)

    // Other requests, output free: result comes via the execute and output registers
    `CHK_LAT2(a_result_lat, i_clk, i_rst_n,
        in_acc && (i_in_item.op != OP_LOAD) && !o_out_valid, o_out_valid)

endmodule

bind pcm_pwm_dac_feeder_core ppdf_sva u_ppdf_sva (.*);

// ===== test/ppdf_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and APB channels of the PCM feeder, keeps its own
// copy of the sample store and playback state, and compares every result.
module ppdf_checker
    import ppdf_pkg::*;
#(
    parameter int STORE_DEPTH = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [31:0]          i_pwdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int unsigned DUTY_GAIN = 4;

    logic [7:0]  sample_mem [STORE_DEPTH];
    logic [15:0] play_pos;
    logic [11:0] phase_acc;
    logic        playback_on;

    logic [1:0]  cfg_format;
    logic [3:0]  cfg_channels;
    logic [15:0] cfg_step;
    logic [9:0]  cfg_volume;
    logic [14:0] cfg_length;

    t_out_item   expected_results [$];
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Bytes past the end of the store read as zero.
    function automatic int unsigned stored_byte(input int unsigned addr);
        if (addr < STORE_DEPTH) return sample_mem[addr];
        return 0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic predict_request(input t_in_item req);
        t_out_item   res;
        int unsigned level;
        int unsigned acc;
        int unsigned steps;
        int unsigned advance;
        int unsigned next_pos;
        int unsigned gain;
        res = '0;
        case (req.op)
            OP_LOAD: begin
                if (req.byte_address < STORE_DEPTH) sample_mem[req.byte_address] = req.byte_value;
            end
            OP_START: begin
                play_pos    = '0;
                phase_acc   = '0;
                playback_on = 1'b1;
                res.playing = 1'b1;
                expected_results.push_back(res);
            end
            OP_STOP: begin
                playback_on = 1'b0;
                expected_results.push_back(res);
            end
            default: begin
                if (!playback_on || play_pos >= cfg_length) begin
                    // idle or past the data: stay put, drop out at the end
                    if (play_pos >= cfg_length) playback_on = 1'b0;
                    res.playing = playback_on;
                end else begin
                    level = MID_LEVEL;
                    if (cfg_format == FMT_U8) begin
                        level = stored_byte(play_pos);
                    end else if (cfg_format == FMT_S16 && play_pos + 1 < cfg_length) begin
                        level = stored_byte(play_pos + 1) ^ SIGN_FLIP;
                    end
                    acc       = phase_acc + cfg_step;
                    steps     = acc >> FRAC_BITS;
                    phase_acc = acc[11:0];
                    if (cfg_format == FMT_U8) advance = steps * cfg_channels;
                    else if (cfg_format == FMT_S16) advance = steps * cfg_channels * 2;
                    else advance = steps;
                    next_pos = play_pos + advance;
                    play_pos = (next_pos > POS_MAX) ? POS_MAX : next_pos[15:0];
                    gain     = (cfg_volume > VOL_FULL) ? VOL_FULL : cfg_volume;
                    res.duty    = (level * DUTY_GAIN * gain) / VOL_FULL;
                    res.playing = 1'b1;
                end
                expected_results.push_back(res);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            play_pos     = '0;
            phase_acc    = '0;
            playback_on  = 1'b0;
            cfg_format   = RST_FORMAT;
            cfg_channels = RST_CHANNELS;
            cfg_step     = RST_STEP;
            cfg_volume   = RST_VOLUME;
            cfg_length   = RST_LENGTH;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding, duty", i_out_item.duty, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.duty !== want.duty)
                        report_mismatch("duty", i_out_item.duty, want.duty);
                    if (i_out_item.playing !== want.playing)
                        report_mismatch("playing", i_out_item.playing, want.playing);
                end
            end
            if (i_in_valid && !i_in_stall) predict_request(i_in_item);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_FORMAT:   cfg_format   = i_pwdata[1:0];
                    REG_CHANNELS: cfg_channels = i_pwdata[3:0];
                    REG_STEP:     cfg_step     = i_pwdata[15:0];
                    REG_VOLUME:   cfg_volume   = i_pwdata[9:0];
                    REG_LENGTH:   cfg_length   = i_pwdata[14:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// Top of the PCM feeder bench: makes the clock, reset, requests and APB writes,
// shapes the stall pattern of the result side, and gives the verdict. All
// prediction and comparison lives in the checker beside the block.
module tb;
    import ppdf_pkg::*;

    // A store smaller than the address range, so that loads past its end and
    // reads past its end both happen.
    localparam int STORE_DEPTH     = 256;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [1:0]  FMT_MID   = 2'd2;    // unsupported, plays mid level
    localparam logic [1:0]  FMT_SPARE = 2'd3;    // likewise, top code
    localparam logic [14:0] LEN_MAX   = 15'h7FFF;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    t_in_item            in_item;
    logic                out_valid;
    logic                out_stall;
    t_out_item           out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int                  mismatches;
    int                  pending_results;
    int                  burst_left;
    bit                  hold_off_req;

    pcm_pwm_dac_feeder_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ppdf_checker #(
        .STORE_DEPTH (STORE_DEPTH)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (mismatches),
        .o_pending    (pending_results)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic t_in_item make_request(input t_op op, input logic [13:0] addr,
                                              input logic [7:0] value);
        t_in_item req;
        req.op           = op;
        req.byte_address = addr;
        req.byte_value   = value;
        return req;
    endfunction

    // Offer one request and hold it until accepted. Requests go out in bursts;
    // at the end of a burst drop valid for a random gap.
    task automatic send_request(input t_in_item req);
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Stop offering, wait for every outstanding result, then give a load still
    // in flight time to retire.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access completes.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_config(input logic [1:0] fmt, input logic [3:0] chans,
                                  input logic [15:0] step, input logic [9:0] vol,
                                  input logic [14:0] len);
        wait_idle();
        write_reg(REG_FORMAT,   32'(fmt));
        write_reg(REG_CHANNELS, 32'(chans));
        write_reg(REG_STEP,     32'(step));
        write_reg(REG_VOLUME,   32'(vol));
        write_reg(REG_LENGTH,   32'(len));
    endtask

    // Result side: pick a stall mode for a stretch of cycles at a time, and
    // hold off completely when asked so that the block fills and stalls intake.
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(32, 400);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 4) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial begin
        int unsigned addr;
        int unsigned pick;
        int unsigned n;
        int unsigned phase_no;
        int unsigned random_items;
        logic [1:0]  fmt;
        logic [3:0]  chans;
        logic [15:0] step;
        logic [9:0]  vol;
        logic [14:0] len;
        t_in_item    req;

        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        burst_left   = 1;
        hold_off_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole store first, so no tick can ever land on an entry
        // that was never written.
        for (addr = 0; addr < STORE_DEPTH; addr++)
            send_request(make_request(OP_LOAD, addr[13:0], 8'($urandom)));

        // Directed: reset settings have no data, so ticks play nothing.
        send_request(make_request(OP_TICK,  14'h3FFF, 8'hFF));
        send_request(make_request(OP_START, 14'h0000, 8'h00));
        send_request(make_request(OP_TICK,  14'h0000, 8'h00));
        send_request(make_request(OP_STOP,  14'h3FFF, 8'hFF));
        send_request(make_request(OP_TICK,  14'h1555, 8'hAA));

        // Extreme sample bytes at the head of the store; the last load lies
        // past the end of the store and must be dropped.
        send_request(make_request(OP_LOAD, 14'd0, 8'hFF));
        send_request(make_request(OP_LOAD, 14'd1, 8'h00));
        send_request(make_request(OP_LOAD, 14'd2, 8'h80));
        send_request(make_request(OP_LOAD, 14'd3, 8'h7F));
        send_request(make_request(OP_LOAD, 14'h3FFF, 8'h55));

        // Unsigned bytes at one per tick, volume above full scale, run off the end.
        program_config(FMT_U8, 4'd1, 16'd4096, 10'h3FF, 15'd4);
        send_request(make_request(OP_START, 14'h0000, 8'h00));
        repeat (5) send_request(make_request(OP_TICK, 14'h0000, 8'h00));

        // Signed 16-bit: a full sample, then a short one whose high byte lies
        // past the data, then the end.
        program_config(FMT_S16, 4'd1, 16'd4096, VOL_FULL, 15'd3);
        send_request(make_request(OP_START, 14'h0000, 8'h00));
        repeat (3) send_request(make_request(OP_TICK, 14'h0000, 8'h00));

        // Unsupported format with the largest step and the longest data.
        program_config(FMT_MID, 4'd8, 16'hFFFF, 10'd500, LEN_MAX);
        send_request(make_request(OP_START, 14'h0000, 8'h00));
        repeat (2) send_request(make_request(OP_TICK, 14'h0000, 8'h00));
        send_request(make_request(OP_STOP, 14'h0000, 8'h00));

        // Random phases: fresh settings, mostly a start followed by ticks, with
        // loads, restarts and stops mixed in.
        phase_no     = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            phase_no++;
            pick = $urandom_range(0, 99);
            if (pick < 35)      fmt = FMT_U8;
            else if (pick < 70) fmt = FMT_S16;
            else if (pick < 85) fmt = FMT_MID;
            else                fmt = FMT_SPARE;
            pick = $urandom_range(0, 99);
            if (pick < 10)      chans = 4'd0;
            else if (pick < 20) chans = 4'hF;
            else                chans = 4'($urandom_range(1, 8));
            pick = $urandom_range(0, 99);
            if (pick < 15)      step = 16'd0;
            else if (pick < 30) step = 16'hFFFF;
            else if (pick < 70) step = 16'($urandom_range(256, 8192));
            else                step = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 20)      vol = VOL_FULL;
            else if (pick < 30) vol = 10'h3FF;
            else if (pick < 40) vol = 10'd0;
            else                vol = 10'($urandom_range(0, 1023));
            pick = $urandom_range(0, 99);
            if (pick < 10)      len = 15'd0;
            else if (pick < 15) len = LEN_MAX;
            else if (pick < 20) len = 15'(STORE_DEPTH + $urandom_range(1, 64));
            else if (pick < 30) len = 15'($urandom_range(0, LEN_MAX));
            else                len = 15'($urandom_range(1, 600));
            program_config(fmt, chans, step, vol, len);

            n = $urandom_range(10, 100);
            if (phase_no % 8 == 2) begin
                // hold the result side off while requests keep coming
                hold_off_req = 1'b1;
                burst_left   = 300;
                n            = 150;
            end

            if ($urandom_range(0, 9) != 0)
                send_request(make_request(OP_START, 14'($urandom), 8'($urandom)));
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    req = make_request(OP_TICK, 14'($urandom), 8'($urandom));
                end else if (pick < 85) begin
                    if ($urandom_range(0, 9) < 7) addr = $urandom_range(0, STORE_DEPTH - 1);
                    else addr = $urandom_range(0, 16383);
                    req = make_request(OP_LOAD, addr[13:0], 8'($urandom));
                end else if (pick < 93) begin
                    req = make_request(OP_START, 14'($urandom), 8'($urandom));
                end else begin
                    req = make_request(OP_STOP, 14'($urandom), 8'($urandom));
                end
                send_request(req);
                // loads the block drops do not count
                if (!(req.op == OP_LOAD && req.byte_address >= STORE_DEPTH)) random_items++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ppdf_pkg.sv
rtl/ppdf_ram.sv
rtl/ppdf_cfg.sv
rtl/pcm_pwm_dac_feeder_core.sv
rtl/ppdf_checker.sv
test/ppdf_checker.sv
test/tb.sv
